/* rtl/tcq_pkg.sv */
`default_nettype none

package tcq_pkg;

    typedef struct packed {
        logic [31:0] cmd;
        logic [7:0]  delay;
    } t_slot;

    typedef struct packed {
        logic        req_type;
        logic [31:0] command_word;
        logic [7:0]  delay_minutes;
        logic [7:0]  elapsed_minutes;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] head_command;
        logic [7:0]  head_delay;
        logic [3:0]  entry_count;
        logic        pending;
    } t_rsp;

    // operands and results of the shared delay unit
    typedef struct packed {
        logic [7:0] a;
        logic [7:0] b;
    } t_alu_op;

    typedef struct packed {
        logic       gt;
        logic [7:0] sat;
    } t_alu_res;

    localparam logic       REQ_INSERT = 1'b0;
    localparam logic       REQ_DELETE = 1'b1;

    localparam logic [1:0] ST_FULL    = 2'd0;
    localparam logic [1:0] ST_FIRST   = 2'd1;
    localparam logic [1:0] ST_INSERT  = 2'd2;
    localparam logic [1:0] ST_DELETE  = 2'd3;

    localparam logic [15:0] EMPTY_TOP  = 16'hFFFF;
    localparam t_slot       EMPTY_SLOT = '1;

    function automatic logic occupied(input t_slot s);
        return s.cmd[31:16] != EMPTY_TOP;
    endfunction

endpackage

`default_nettype wire

/* rtl/tcq_chan_if.sv */
`default_nettype none

interface tcq_chan_if #(parameter type t_payload = logic) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/timed_command_queue_core.sv */
`default_nettype none

// Table of SLOTS time-tagged commands kept sorted by delay, with the nearest
// entry reported on every request word. Requests are taken one at a time:
// ready is high only while the sequencer is idle, and a finished response
// waits in an output register so the next request can already be taken. All
// work runs through one slot memory with one read port and one write port
// and one shared compare/subtract unit. The exchange sort makes one compare
// per cycle, and the rebase and count passes take one slot per cycle. Reset
// needs no clearing pass: per-slot valid bits make unwritten slots read as
// empty.
module timed_command_queue_core #(
    parameter int SLOTS = 10
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    tcq_chan_if.sink   i_req,
    tcq_chan_if.source o_rsp
);
    import tcq_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [IW-1:0] LAST   = IW'(SLOTS - 1);
    localparam logic [IW-1:0] I_LAST = IW'(SLOTS - 2);
    localparam logic [CW-1:0] FULL   = CW'(SLOTS);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_WR0     = 4'd1;
    localparam logic [3:0] S_WRLAST  = 4'd2;
    localparam logic [3:0] S_RB_ST   = 4'd3;
    localparam logic [3:0] S_RB      = 4'd4;
    localparam logic [3:0] S_SO_LDI  = 4'd5;
    localparam logic [3:0] S_SO_GETI = 4'd6;
    localparam logic [3:0] S_SO_CMP  = 4'd7;
    localparam logic [3:0] S_SO_WRI  = 4'd8;
    localparam logic [3:0] S_CN_ST   = 4'd9;
    localparam logic [3:0] S_CN      = 4'd10;
    localparam logic [3:0] S_FIN     = 4'd11;

    logic [3:0]    r_state, n_state;
    t_req          r_req;
    logic [1:0]    r_status;
    logic [IW-1:0] r_i, r_j, r_k;
    t_slot         r_cur;
    t_slot         r_slot0;
    logic [CW-1:0] r_acc;
    logic [CW-1:0] r_count;
    logic          r_in_use;
    logic [31:0]   r_head_cmd;
    logic [7:0]    r_head_delay;
    t_rsp          r_rsp;
    logic          r_rsp_valid;

    logic          accept;
    logic          out_free;
    logic [1:0]    acc_status;
    logic          is_insert;
    logic          we;
    logic [IW-1:0] waddr, raddr;
    t_slot         wdata, rd_slot;
    t_alu_op       alu_op;
    t_alu_res      alu_res;
    logic [CW-1:0] acc_next;
    logic          fin_load, fin_in_use;
    logic [CW+3:0] cnt_ext;
    t_slot         entry;

    tcq_slot_ram #(.DEPTH(SLOTS)) u_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd_slot)
    );

    tcq_alu u_alu (
        .i_op  (alu_op),
        .o_res (alu_res)
    );

    assign i_req.ready   = (r_state == S_IDLE);
    assign accept        = i_req.valid && i_req.ready;
    assign out_free      = !r_rsp_valid || o_rsp.ready;
    assign o_rsp.valid   = r_rsp_valid;
    assign o_rsp.payload = r_rsp;
    assign is_insert     = (r_req.req_type == REQ_INSERT);
    assign entry         = {r_req.command_word, r_req.delay_minutes};
    assign acc_next      = r_acc + CW'(occupied(rd_slot));
    assign cnt_ext       = {4'b0, r_count};

    always_comb begin
        if (i_req.payload.req_type == REQ_DELETE) begin
            acc_status = ST_DELETE;
        end else if (r_count >= FULL) begin
            acc_status = ST_FULL;
        end else if (r_in_use && (r_count != '0)) begin
            acc_status = ST_INSERT;
        end else begin
            acc_status = ST_FIRST;
        end
    end

    // shared unit: rebase subtracts elapsed time, sort compares delays
    always_comb begin
        if (r_state == S_RB) begin
            alu_op.a = rd_slot.delay;
            alu_op.b = r_req.elapsed_minutes;
        end else begin
            alu_op.a = r_cur.delay;
            alu_op.b = rd_slot.delay;
        end
    end

    always_comb begin
        we    = 1'b0;
        waddr = '0;
        wdata = r_cur;
        raddr = '0;
        case (r_state)
            S_WR0: begin
                we    = 1'b1;
                wdata = is_insert ? entry : EMPTY_SLOT;
            end
            S_WRLAST: begin
                we    = 1'b1;
                waddr = LAST;
                wdata = entry;
            end
            S_RB: begin
                we    = occupied(rd_slot);
                waddr = r_k;
                wdata = {rd_slot.cmd, alu_res.sat};
                raddr = (r_k == LAST) ? r_k : r_k + IW'(1);
            end
            S_SO_LDI: begin
                raddr = r_i;
            end
            S_SO_GETI: begin
                raddr = r_j;
            end
            S_SO_CMP: begin
                we    = alu_res.gt;
                waddr = r_j;
                raddr = (r_j == LAST) ? r_j : r_j + IW'(1);
            end
            S_SO_WRI: begin
                we    = 1'b1;
                waddr = r_i;
            end
            S_CN: begin
                raddr = (r_k == LAST) ? r_k : r_k + IW'(1);
            end
            default: begin
                raddr = '0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (acc_status)
                        ST_FULL:   n_state = S_FIN;
                        ST_INSERT: n_state = S_RB_ST;
                        default:   n_state = S_WR0;
                    endcase
                end
            end
            S_WR0:     n_state = is_insert ? S_CN_ST : S_SO_LDI;
            S_WRLAST:  n_state = S_SO_LDI;
            S_RB_ST:   n_state = S_RB;
            S_RB: begin
                if (r_k == LAST) begin
                    n_state = is_insert ? S_WRLAST : S_CN_ST;
                end
            end
            S_SO_LDI:  n_state = S_SO_GETI;
            S_SO_GETI: n_state = S_SO_CMP;
            S_SO_CMP: begin
                if (r_j == LAST) begin
                    n_state = S_SO_WRI;
                end
            end
            S_SO_WRI: begin
                if (r_i == I_LAST) begin
                    n_state = is_insert ? S_CN_ST : S_RB_ST;
                end else begin
                    n_state = S_SO_LDI;
                end
            end
            S_CN_ST:   n_state = S_CN;
            S_CN: begin
                if (r_k == LAST) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        case (r_status)
            ST_FULL: begin
                fin_load   = 1'b0;
                fin_in_use = r_in_use;
            end
            ST_DELETE: begin
                fin_load   = occupied(r_slot0);
                fin_in_use = occupied(r_slot0);
            end
            default: begin
                fin_load   = 1'b1;
                fin_in_use = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_in_use     <= 1'b0;
            r_head_cmd   <= '0;
            r_head_delay <= '0;
            r_rsp_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_CN) && (r_k == LAST)) begin
                r_count <= acc_next;
            end
            if ((r_state == S_FIN) && out_free) begin
                r_rsp_valid <= 1'b1;
                r_in_use    <= fin_in_use;
                if (fin_load) begin
                    r_head_cmd   <= r_slot0.cmd;
                    r_head_delay <= r_slot0.delay;
                end
            end else if (o_rsp.valid && o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_req    <= i_req.payload;
                    r_status <= acc_status;
                end
            end
            S_WR0, S_WRLAST: begin
                r_i <= '0;
            end
            S_RB_ST: begin
                r_k <= '0;
            end
            S_RB: begin
                r_k <= r_k + IW'(1);
            end
            S_SO_LDI: begin
                r_j <= r_i + IW'(1);
            end
            S_SO_GETI: begin
                r_cur <= rd_slot;
            end
            S_SO_CMP: begin
                if (alu_res.gt) begin
                    r_cur <= rd_slot;
                end
                r_j <= r_j + IW'(1);
            end
            S_SO_WRI: begin
                r_i <= r_i + IW'(1);
            end
            S_CN_ST: begin
                r_k   <= '0;
                r_acc <= '0;
            end
            S_CN: begin
                if (r_k == '0) begin
                    r_slot0 <= rd_slot;
                end
                r_acc <= acc_next;
                r_k   <= r_k + IW'(1);
            end
            S_FIN: begin
                if (out_free) begin
                    r_rsp.status       <= r_status;
                    r_rsp.head_command <= fin_load ? r_slot0.cmd : r_head_cmd;
                    r_rsp.head_delay   <= fin_load ? r_slot0.delay : r_head_delay;
                    r_rsp.entry_count  <= cnt_ext[3:0];
                    r_rsp.pending      <= fin_in_use;
                end
            end
            default: begin
                r_k <= r_k;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    ap_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL)
        else $error("occupied count above slot count");

    ap_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !i_req.ready)
        else $error("ready right after a request word");

    ap_sort_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SO_CMP) |-> (r_j > r_i))
        else $error("sort compares a slot against itself or an earlier one");

    ap_idle_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.payload.pending) |->
        (o_rsp.payload.status == ST_DELETE || o_rsp.payload.status == ST_FULL))
        else $error("table idle after a stored insert");
`endif

endmodule

`default_nettype wire

/* rtl/tcq_alu.sv */
`default_nettype none

module tcq_alu (
    input  tcq_pkg::t_alu_op  i_op,
    output tcq_pkg::t_alu_res o_res
);
    import tcq_pkg::*;

    logic [8:0] diff;

    // one subtractor gives both the compare and the saturating difference
    assign diff      = {1'b0, i_op.a} - {1'b0, i_op.b};
    assign o_res.gt  = !diff[8] && (diff[7:0] != 8'd0);
    assign o_res.sat = o_res.gt ? diff[7:0] : 8'd0;

endmodule

`default_nettype wire

/* rtl/tcq_slot_ram.sv */
`default_nettype none

module tcq_slot_ram #(
    parameter int DEPTH = 10
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_we,
    input  wire  [$clog2(DEPTH)-1:0]  i_waddr,
    input  tcq_pkg::t_slot            i_wdata,
    input  wire  [$clog2(DEPTH)-1:0]  i_raddr,
    output tcq_pkg::t_slot            o_rdata
);
    import tcq_pkg::*;

    t_slot              r_mem [DEPTH];
    logic [DEPTH-1:0]   r_valid;
    t_slot              r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // never written slots read as empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_valid[i_raddr] ? r_mem[i_raddr] : EMPTY_SLOT;
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
